FILE: src/fct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the cluster chain table engine.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int CLUSTER_W = 16;
    localparam int SIZE_W    = 32;
    localparam int CSIZE_W   = 21;
    localparam int ALU_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    localparam logic [CLUSTER_W-1:0] ENTRY_FREE = 16'h0000;
    localparam logic [CLUSTER_W-1:0] ENTRY_EOC  = 16'hFFFF;
    localparam int                   FIRST_DATA = 2;

    typedef enum logic [2:0] {
        OP_FIND     = 3'd0,
        OP_MARK_END = 3'd1,
        OP_GET_NEXT = 3'd2,
        OP_LINK     = 3'd3,
        OP_FREE     = 3'd4,
        OP_ALLOC    = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUNTED = 2'd0,
        CFG_TOTAL   = 2'd1,
        CFG_SPC     = 2'd2,
        CFG_BPS     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        mounted;
        logic [11:0] data_clusters;
        logic [7:0]  clu_sectors;
        logic [12:0] sector_bytes;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_SCAN,
        ST_LINK,
        ST_STEP,
        ST_RESP
    } t_state;

endpackage
`default_nettype wire

FILE: src/fct_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_req_if
// Request channel: one operation on the chain table per item.
// ----------------------------------------------------------------------------
interface fct_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] cluster;
    logic [15:0] link_value;
    logic [31:0] byte_size;

    modport source (output valid, op, cluster, link_value, byte_size, input ready);
    modport sink   (input valid, op, cluster, link_value, byte_size, output ready);
endinterface
`default_nettype wire

FILE: src/fct_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_rsp_if
// Response channel: status and cluster number, one item per request.
// ----------------------------------------------------------------------------
interface fct_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] cluster_result;

    modport source (output valid, ok, cluster_result, input ready);
    modport sink   (input valid, ok, cluster_result, output ready);
endinterface
`default_nettype wire

FILE: src/fct_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_alu
// Shared subtract / compare unit: bounds checks, scan limit, byte countdown.
// ----------------------------------------------------------------------------
module fct_alu (
    input  wire logic [fct_pkg::ALU_W-1:0] i_a,
    input  wire logic [fct_pkg::ALU_W-1:0] i_b,
    output logic      [fct_pkg::ALU_W-1:0] o_diff,
    output logic                           o_lt,
    output logic                           o_le
);

    logic [fct_pkg::ALU_W:0] wide_diff;

    always_comb begin
        wide_diff = {1'b0, i_a} - {1'b0, i_b};
        o_diff    = wide_diff[fct_pkg::ALU_W-1:0];
        o_lt      = wide_diff[fct_pkg::ALU_W];
        o_le      = wide_diff[fct_pkg::ALU_W] || (o_diff == '0);
    end

endmodule
`default_nettype wire

FILE: src/fct_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_table
// Chain link memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fct_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_wr_en,
    input  wire logic [AW-1:0]                     i_wr_addr,
    input  wire logic [fct_pkg::CLUSTER_W-1:0]     i_wr_data,
    input  wire logic [AW-1:0]                     i_rd_addr,
    output logic      [fct_pkg::CLUSTER_W-1:0]     o_rd_data
);

    logic [fct_pkg::CLUSTER_W-1:0] mem [DEPTH];
    logic [fct_pkg::CLUSTER_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: src/fct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fct_ctrl
// Sequencer: clearing pass, decode, pipelined free scan and chain building.
// ----------------------------------------------------------------------------
module fct_ctrl #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int AW            = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fct_pkg::t_cfg                 i_cfg,
    fct_req_if.sink                            i_req,
    fct_rsp_if.source                          o_rsp,
    output logic                               o_wr_en,
    output logic [AW-1:0]                      o_wr_addr,
    output logic [fct_pkg::CLUSTER_W-1:0]      o_wr_data,
    output logic [AW-1:0]                      o_rd_addr,
    input  wire logic [fct_pkg::CLUSTER_W-1:0] i_rd_data
);

    localparam int PW = AW + 1;
    localparam int LW = (PW > 13) ? PW : 13;
    localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_ENTRIES - 1);
    localparam logic [LW-1:0] DEPTH_LW   = LW'(TABLE_ENTRIES);
    localparam logic [PW-1:0] FIRST_PW   = PW'(fct_pkg::FIRST_DATA);

    fct_pkg::t_state r_state, n_state;

    logic [2:0]                      r_op, n_op;
    logic [fct_pkg::CLUSTER_W-1:0]   r_cluster, n_cluster;
    logic [fct_pkg::CLUSTER_W-1:0]   r_link, n_link;
    logic [fct_pkg::SIZE_W-1:0]      r_rem, n_rem;
    logic [fct_pkg::CSIZE_W-1:0]     r_csize, n_csize;
    logic [AW-1:0]                   r_clr, n_clr;
    logic [PW-1:0]                   r_ptr, n_ptr;
    logic                            r_chk_v, n_chk_v;
    logic [AW-1:0]                   r_chk_addr, n_chk_addr;
    logic [AW-1:0]                   r_hit, n_hit;
    logic [AW-1:0]                   r_cur, n_cur;
    logic [AW-1:0]                   r_first, n_first;
    logic                            r_first_done, n_first_done;
    logic                            r_ok, n_ok;
    logic [fct_pkg::CLUSTER_W-1:0]   r_res, n_res;
    logic                            r_out_valid, n_out_valid;
    logic                            r_out_ok, n_out_ok;
    logic [fct_pkg::CLUSTER_W-1:0]   r_out_res, n_out_res;

    logic [LW-1:0]                   tot_lim;
    logic [PW-1:0]                   lim;
    logic [fct_pkg::ALU_W-1:0]       alu_a, alu_b, alu_diff;
    logic                            alu_lt, alu_le;
    logic                            accept, found, scan_miss, clu_ok, op_write, rsp_load;
    logic [fct_pkg::CLUSTER_W-1:0]   wr_val;

    // upper cluster bound, saturated at the table depth
    always_comb begin
        tot_lim = LW'(i_cfg.data_clusters) + LW'(fct_pkg::FIRST_DATA);
        lim     = (tot_lim > DEPTH_LW) ? PW'(DEPTH_LW) : PW'(tot_lim);
    end

    always_comb begin
        case (r_state)
            fct_pkg::ST_DECODE: begin
                alu_a = fct_pkg::ALU_W'(r_cluster);
                alu_b = fct_pkg::ALU_W'(lim);
            end
            fct_pkg::ST_SCAN: begin
                alu_a = fct_pkg::ALU_W'(r_ptr);
                alu_b = fct_pkg::ALU_W'(lim);
            end
            default: begin
                alu_a = r_rem;
                alu_b = fct_pkg::ALU_W'(r_csize);
            end
        endcase
    end

    fct_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_diff),
        .o_lt   (alu_lt),
        .o_le   (alu_le)
    );

    always_comb begin
        accept    = (r_state == fct_pkg::ST_IDLE) && i_req.valid;
        found     = r_chk_v && (i_rd_data == fct_pkg::ENTRY_FREE);
        scan_miss = !r_chk_v && !alu_lt;
        clu_ok    = i_cfg.mounted && (r_cluster >= fct_pkg::CLUSTER_W'(fct_pkg::FIRST_DATA))
                    && alu_lt;
        op_write  = r_op inside {fct_pkg::OP_MARK_END, fct_pkg::OP_LINK, fct_pkg::OP_FREE};
        rsp_load  = (r_state == fct_pkg::ST_RESP) && (!r_out_valid || o_rsp.ready);
        case (r_op)
            fct_pkg::OP_MARK_END: wr_val = fct_pkg::ENTRY_EOC;
            fct_pkg::OP_LINK:     wr_val = r_link;
            default:              wr_val = fct_pkg::ENTRY_FREE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fct_pkg::ST_CLEAR: begin
                if (r_clr == LAST_ENTRY) n_state = fct_pkg::ST_IDLE;
            end
            fct_pkg::ST_IDLE: begin
                if (i_req.valid) n_state = fct_pkg::ST_DECODE;
            end
            fct_pkg::ST_DECODE: begin
                n_state = fct_pkg::ST_RESP;
                if (i_cfg.mounted) begin
                    case (r_op)
                        fct_pkg::OP_FIND:     n_state = fct_pkg::ST_SCAN;
                        fct_pkg::OP_GET_NEXT: if (clu_ok) n_state = fct_pkg::ST_READ;
                        fct_pkg::OP_ALLOC: begin
                            if ((r_rem != '0) && (r_csize != '0)) n_state = fct_pkg::ST_SCAN;
                        end
                        default: n_state = fct_pkg::ST_RESP;
                    endcase
                end
            end
            fct_pkg::ST_READ: n_state = fct_pkg::ST_RESP;
            fct_pkg::ST_SCAN: begin
                if (found) begin
                    if (r_op != fct_pkg::OP_ALLOC) n_state = fct_pkg::ST_RESP;
                    else if (r_first_done)         n_state = fct_pkg::ST_LINK;
                    else                           n_state = fct_pkg::ST_STEP;
                end else if (scan_miss) begin
                    n_state = fct_pkg::ST_RESP;
                end
            end
            fct_pkg::ST_LINK: n_state = fct_pkg::ST_STEP;
            fct_pkg::ST_STEP: n_state = alu_le ? fct_pkg::ST_RESP : fct_pkg::ST_SCAN;
            fct_pkg::ST_RESP: begin
                if (rsp_load) n_state = fct_pkg::ST_IDLE;
            end
            default: n_state = fct_pkg::ST_CLEAR;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cluster[AW-1:0];
        o_wr_data   = wr_val;
        o_rd_addr   = r_cluster[AW-1:0];
        i_req.ready = (r_state == fct_pkg::ST_IDLE);
        case (r_state)
            fct_pkg::ST_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = fct_pkg::ENTRY_FREE;
            end
            fct_pkg::ST_DECODE: begin
                o_wr_en = clu_ok && op_write;
            end
            fct_pkg::ST_SCAN: begin
                o_rd_addr = r_ptr[AW-1:0];
                o_wr_en   = found && (r_op == fct_pkg::OP_ALLOC);
                o_wr_addr = r_chk_addr;
                o_wr_data = fct_pkg::ENTRY_EOC;
            end
            fct_pkg::ST_LINK: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_cur;
                o_wr_data = fct_pkg::CLUSTER_W'(r_hit);
            end
            default: o_wr_en = 1'b0;
        endcase
    end

    // datapath registers
    always_comb begin
        n_op         = r_op;
        n_cluster    = r_cluster;
        n_link       = r_link;
        n_rem        = r_rem;
        n_csize      = r_csize;
        n_clr        = r_clr;
        n_ptr        = r_ptr;
        n_chk_v      = r_chk_v;
        n_chk_addr   = r_chk_addr;
        n_hit        = r_hit;
        n_cur        = r_cur;
        n_first      = r_first;
        n_first_done = r_first_done;
        n_ok         = r_ok;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_ok     = r_out_ok;
        n_out_res    = r_out_res;
        case (r_state)
            fct_pkg::ST_CLEAR: n_clr = r_clr + AW'(1);
            fct_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op      = i_req.op;
                    n_cluster = i_req.cluster;
                    n_link    = i_req.link_value;
                    n_rem     = i_req.byte_size;
                    n_csize   = fct_pkg::CSIZE_W'(i_cfg.clu_sectors)
                                * fct_pkg::CSIZE_W'(i_cfg.sector_bytes);
                    n_ok      = 1'b0;
                    n_res     = '0;
                end
            end
            fct_pkg::ST_DECODE: begin
                n_ok         = clu_ok && op_write;
                n_ptr        = FIRST_PW;
                n_chk_v      = 1'b0;
                n_first_done = 1'b0;
            end
            fct_pkg::ST_READ: begin
                n_ok  = 1'b1;
                n_res = i_rd_data;
            end
            fct_pkg::ST_SCAN: begin
                if (found) begin
                    n_chk_v = 1'b0;
                    n_hit   = r_chk_addr;
                    if (r_op != fct_pkg::OP_ALLOC) begin
                        n_ok  = 1'b1;
                        n_res = fct_pkg::CLUSTER_W'(r_chk_addr);
                    end else if (!r_first_done) begin
                        n_first      = r_chk_addr;
                        n_cur        = r_chk_addr;
                        n_first_done = 1'b1;
                    end
                end else if (alu_lt) begin
                    // issue the next read, check its data in the next cycle
                    n_ptr      = r_ptr + PW'(1);
                    n_chk_v    = 1'b1;
                    n_chk_addr = r_ptr[AW-1:0];
                end else begin
                    n_chk_v = 1'b0;
                end
            end
            fct_pkg::ST_LINK: n_cur = r_hit;
            fct_pkg::ST_STEP: begin
                if (alu_le) begin
                    n_ok  = 1'b1;
                    n_res = fct_pkg::CLUSTER_W'(r_first);
                end else begin
                    n_rem   = alu_diff;
                    n_ptr   = PW'(r_cur) + PW'(1);
                    n_chk_v = 1'b0;
                end
            end
            fct_pkg::ST_RESP: begin
                if (rsp_load) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_out_res   = r_res;
                end
            end
            default: n_clr = r_clr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= fct_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_chk_v      <= 1'b0;
            r_first_done <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_chk_v      <= n_chk_v;
            r_first_done <= n_first_done;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_cluster  <= n_cluster;
        r_link     <= n_link;
        r_rem      <= n_rem;
        r_csize    <= n_csize;
        r_ptr      <= n_ptr;
        r_chk_addr <= n_chk_addr;
        r_hit      <= n_hit;
        r_cur      <= n_cur;
        r_first    <= n_first;
        r_ok       <= n_ok;
        r_res      <= n_res;
        r_out_ok   <= n_out_ok;
        r_out_res  <= n_out_res;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.ok             = r_out_ok;
    assign o_rsp.cluster_result = r_out_res;

    // only data clusters are written once the clearing pass is over
    a_wr_data_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr_en && (r_state != fct_pkg::ST_CLEAR)) |-> (o_wr_addr >= AW'(fct_pkg::FIRST_DATA)))
        else $error("write below first data cluster");

    // a scan read never goes past the cluster bound
    a_chk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_v |-> (PW'(r_chk_addr) < lim))
        else $error("scan checked entry beyond limit");

    // a rejected item carries cluster 0
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_res == '0))
        else $error("failed item with nonzero cluster");

    // an accepted item is decoded in the following cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == fct_pkg::ST_DECODE))
        else $error("accepted item not decoded");

endmodule
`default_nettype wire

FILE: src/fat_cluster_table_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fat_cluster_table_engine
// FAT16 cluster chain table: free search, link access and chain allocation.
//
//   channel   dir  payload                                 handshake
//   i_req     in   op, cluster, link_value, byte_size      valid / ready
//   o_rsp     out  ok, cluster_result                      valid / ready
//   i_cfg_*   in   register index, write data              write enable
//
// One item at a time. Mark end, link, free and rejected items go from decode
// to the response; get next first reads the entry. Find free scans up from
// the first data cluster, reading one table entry per cycle from the memory
// port and checking it in the next cycle. Allocation runs one scan per
// cluster, each past the last one taken, marks the hit as end of chain, links
// it to the previous one and counts down the bytes. After reset a clearing
// pass zeroes the table; ready is low meanwhile. A finished item waits in the
// output register, so a stalled response side holds only the next item's end.
// ----------------------------------------------------------------------------
module fat_cluster_table_engine #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [fct_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [fct_pkg::CFG_DAT_W-1:0] i_cfg_wdata,
    fct_req_if.sink                            i_req,
    fct_rsp_if.source                          o_rsp
);

    localparam int AW = $clog2(TABLE_ENTRIES);

    fct_pkg::t_cfg                 r_cfg;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [fct_pkg::CLUSTER_W-1:0] wr_data;
    logic [AW-1:0]                 rd_addr;
    logic [fct_pkg::CLUSTER_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mounted       <= 1'b0;
            r_cfg.data_clusters <= 12'd0;
            r_cfg.clu_sectors   <= 8'd1;
            r_cfg.sector_bytes  <= 13'd512;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fct_pkg::CFG_MOUNTED: r_cfg.mounted       <= i_cfg_wdata[0];
                fct_pkg::CFG_TOTAL:   r_cfg.data_clusters <= i_cfg_wdata[11:0];
                fct_pkg::CFG_SPC:     r_cfg.clu_sectors   <= i_cfg_wdata[7:0];
                fct_pkg::CFG_BPS:     r_cfg.sector_bytes  <= i_cfg_wdata;
                default:              r_cfg.mounted       <= r_cfg.mounted;
            endcase
        end
    end

    fct_table #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fct_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

endmodule
`default_nettype wire

FILE: bench/fat_cluster_table_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_table_engine_test
// Self-checking bench for the cluster chain table engine. A shadow copy of
// the chain table predicts every response. Directed corner cases run first,
// then random operations under several geometries, with random gaps on both
// channels and one long response stall that backs up the request side.
// ----------------------------------------------------------------------------
module fat_cluster_table_engine_test;

    localparam int         TBL_DEPTH    = 4096;
    localparam logic [2:0] OP_RSVD_6    = 3'd6;
    localparam logic [2:0] OP_RSVD_7    = 3'd7;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = 50;
    localparam int         MAX_REPORTS  = 10;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] cluster;
        logic [15:0] link_value;
        logic [31:0] byte_size;
    } t_req;

    typedef struct {
        logic        ok;
        logic [15:0] cluster_result;
    } t_rsp;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [fct_pkg::CFG_IDX_W-1:0] i_cfg_idx   = fct_pkg::CFG_MOUNTED;
    logic [fct_pkg::CFG_DAT_W-1:0] i_cfg_wdata = '0;

    fct_req_if req_ch ();
    fct_rsp_if rsp_ch ();

    fat_cluster_table_engine #(
        .TABLE_ENTRIES(TBL_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // shadow table and register copies
    logic [15:0] shadow_fat [0:TBL_DEPTH-1];
    int unsigned sh_mounted = 0;
    int unsigned sh_total   = 0;
    int unsigned sh_spc     = 1;
    int unsigned sh_bps     = 512;

    t_req        pending_reqs [$];
    t_rsp        predicted_rsps [$];
    t_req        req_on_bus;
    t_rsp        rsp_want;
    int unsigned req_gap    = 0;
    int unsigned rsp_stall  = 0;
    int unsigned mismatches = 0;
    logic        gaps_on    = 1'b1;
    logic        hold_go    = 1'b0;
    logic        rsp_hold   = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned table_limit();
        int unsigned lim;
        lim = sh_total + fct_pkg::FIRST_DATA;
        if (lim > TBL_DEPTH) begin
            lim = TBL_DEPTH;
        end
        return lim;
    endfunction

    function automatic logic cluster_ok(logic [15:0] c);
        return (c >= fct_pkg::FIRST_DATA) && (c < table_limit());
    endfunction

    function automatic int unsigned lowest_free(int unsigned start);
        int unsigned idx;
        idx = (start < fct_pkg::FIRST_DATA) ? fct_pkg::FIRST_DATA : start;
        while (idx < table_limit()) begin
            if (shadow_fat[idx] == fct_pkg::ENTRY_FREE) begin
                return idx;
            end
            idx++;
        end
        return 0;
    endfunction

    // each cluster is marked taken before the next search; a partial chain stays
    function automatic logic allocate_chain(logic [31:0] size, output logic [15:0] head);
        longint unsigned csize;
        longint unsigned needed;
        longint unsigned n;
        int unsigned     cur;
        int unsigned     nxt;
        head  = '0;
        csize = 64'(sh_spc);
        csize = csize * 64'(sh_bps);
        if (size == 0 || csize == 0) begin
            return 1'b0;
        end
        needed = (64'(size) + csize - 64'd1) / csize;
        cur = lowest_free(fct_pkg::FIRST_DATA);
        if (cur == 0) begin
            return 1'b0;
        end
        head = cur[15:0];
        shadow_fat[cur] = fct_pkg::ENTRY_EOC;
        for (n = 1; n < needed; n++) begin
            nxt = lowest_free(cur + 1);
            if (nxt == 0) begin
                return 1'b0;
            end
            shadow_fat[cur] = nxt[15:0];
            shadow_fat[nxt] = fct_pkg::ENTRY_EOC;
            cur = nxt;
        end
        return 1'b1;
    endfunction

    function automatic t_rsp run_table_op(t_req r);
        t_rsp        rsp;
        logic [15:0] head;
        int unsigned hit;
        rsp.ok             = 1'b0;
        rsp.cluster_result = '0;
        if (sh_mounted != 0) begin
            case (r.op)
                fct_pkg::OP_FIND: begin
                    hit = lowest_free(fct_pkg::FIRST_DATA);
                    if (hit != 0) begin
                        rsp.ok             = 1'b1;
                        rsp.cluster_result = hit[15:0];
                    end
                end
                fct_pkg::OP_MARK_END: begin
                    if (cluster_ok(r.cluster)) begin
                        shadow_fat[r.cluster] = fct_pkg::ENTRY_EOC;
                        rsp.ok = 1'b1;
                    end
                end
                fct_pkg::OP_GET_NEXT: begin
                    if (cluster_ok(r.cluster)) begin
                        rsp.ok             = 1'b1;
                        rsp.cluster_result = shadow_fat[r.cluster];
                    end
                end
                fct_pkg::OP_LINK: begin
                    if (cluster_ok(r.cluster)) begin
                        shadow_fat[r.cluster] = r.link_value;
                        rsp.ok = 1'b1;
                    end
                end
                fct_pkg::OP_FREE: begin
                    if (cluster_ok(r.cluster)) begin
                        shadow_fat[r.cluster] = fct_pkg::ENTRY_FREE;
                        rsp.ok = 1'b1;
                    end
                end
                fct_pkg::OP_ALLOC: begin
                    if (allocate_chain(r.byte_size, head)) begin
                        rsp.ok             = 1'b1;
                        rsp.cluster_result = head;
                    end
                end
                default: begin
                end
            endcase
        end
        return rsp;
    endfunction

    function automatic t_req make_req(logic [2:0] op, logic [15:0] cl, logic [15:0] lv,
                                      logic [31:0] sz);
        t_req r;
        r.op         = op;
        r.cluster    = cl;
        r.link_value = lv;
        r.byte_size  = sz;
        return r;
    endfunction

    // mostly in-range clusters and modest sizes, with edges and raw noise mixed in
    function automatic t_req random_req();
        t_req            r;
        int unsigned     lim;
        int unsigned     pick;
        int unsigned     span;
        longint unsigned csize;
        lim   = table_limit();
        csize = 64'(sh_spc);
        csize = csize * 64'(sh_bps);
        r.cluster    = 16'($urandom);
        r.link_value = 16'($urandom);
        r.byte_size  = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            r.op = fct_pkg::OP_FIND;
        end else if (pick < 28) begin
            r.op = fct_pkg::OP_MARK_END;
        end else if (pick < 48) begin
            r.op = fct_pkg::OP_GET_NEXT;
        end else if (pick < 64) begin
            r.op = fct_pkg::OP_LINK;
        end else if (pick < 80) begin
            r.op = fct_pkg::OP_FREE;
        end else if (pick < 96) begin
            r.op = fct_pkg::OP_ALLOC;
        end else if (pick < 98) begin
            r.op = OP_RSVD_6;
        end else begin
            r.op = OP_RSVD_7;
        end
        pick = $urandom_range(0, 99);
        if (pick < 85 && lim > fct_pkg::FIRST_DATA) begin
            r.cluster = 16'($urandom_range(fct_pkg::FIRST_DATA, lim - 1));
        end else if (pick < 93) begin
            case ($urandom_range(0, 2))
                0:       r.cluster = 16'd0;
                1:       r.cluster = 16'd1;
                default: r.cluster = lim[15:0];
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 40 && lim > fct_pkg::FIRST_DATA) begin
            r.link_value = 16'($urandom_range(fct_pkg::FIRST_DATA, lim - 1));
        end else if (pick < 55) begin
            r.link_value = fct_pkg::ENTRY_EOC;
        end else if (pick < 62) begin
            r.link_value = fct_pkg::ENTRY_FREE;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70 && csize != 0) begin
            span = 32'(csize * 3);
            r.byte_size = $urandom_range(1, span);
        end else if (pick < 80) begin
            r.byte_size = '0;
        end
        return r;
    endfunction

    task automatic write_reg(input fct_pkg::t_cfg_idx idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value[fct_pkg::CFG_DAT_W-1:0];
        case (idx)
            fct_pkg::CFG_MOUNTED: sh_mounted = value & 32'h1;
            fct_pkg::CFG_TOTAL:   sh_total   = value & 32'hFFF;
            fct_pkg::CFG_SPC:     sh_spc     = value & 32'hFF;
            default:              sh_bps     = value & 32'h1FFF;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned mnt, input int unsigned total,
                                input int unsigned spc, input int unsigned bps);
        write_reg(fct_pkg::CFG_MOUNTED, mnt);
        write_reg(fct_pkg::CFG_TOTAL, total);
        write_reg(fct_pkg::CFG_SPC, spc);
        write_reg(fct_pkg::CFG_BPS, bps);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() != 0 || req_ch.valid || predicted_rsps.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_reqs.push_back(random_req());
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                predicted_rsps.push_back(run_table_op(req_on_bus));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (req_gap != 0) begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req_on_bus = pending_reqs.pop_front();
                    req_ch.op         <= req_on_bus.op;
                    req_ch.cluster    <= req_on_bus.cluster;
                    req_ch.link_value <= req_on_bus.link_value;
                    req_ch.byte_size  <= req_on_bus.byte_size;
                    req_ch.valid      <= 1'b1;
                    req_gap = gaps_on ? $urandom_range(0, 9) : 0;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (predicted_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected response: ok=%0b cluster=%0d",
                                 rsp_ch.ok, rsp_ch.cluster_result);
                    end
                end else begin
                    rsp_want = predicted_rsps.pop_front();
                    if (rsp_ch.ok !== rsp_want.ok
                            || rsp_ch.cluster_result !== rsp_want.cluster_result) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: ok exp %0b got %0b, cluster exp %0d got %0d",
                                     rsp_want.ok, rsp_ch.ok,
                                     rsp_want.cluster_result, rsp_ch.cluster_result);
                        end
                    end
                end
                rsp_stall = gaps_on ? $urandom_range(0, 9) : 0;
            end
            if (rsp_hold) begin
                rsp_ch.ready <= 1'b0;
            end else if (rsp_stall != 0) begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // long response hold so the engine fills up and stalls its request side
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    initial begin
        #60_000_000;
        $display("FAIL fat_cluster_table_engine");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < TBL_DEPTH; k++) begin
            shadow_fat[k] = fct_pkg::ENTRY_FREE;
        end
        req_ch.valid      = 1'b0;
        req_ch.op         = fct_pkg::OP_FIND;
        req_ch.cluster    = '0;
        req_ch.link_value = '0;
        req_ch.byte_size  = '0;
        rsp_ch.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // still unmounted after reset
        @(negedge i_clk);
        pending_reqs.push_back(make_req(fct_pkg::OP_FIND, 16'd0, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd2, 16'd0, 32'd100));
        wait_idle();

        // mounted with no data clusters
        set_geometry(1, 0, 1, 512);
        pending_reqs.push_back(make_req(fct_pkg::OP_FIND, 16'd0, 16'd0, 32'd0));
        wait_idle();

        set_geometry(1, 10, 1, 512);
        pending_reqs.push_back(make_req(fct_pkg::OP_FIND, 16'd0, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_MARK_END, 16'd2, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_GET_NEXT, 16'd2, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_LINK, 16'd11, 16'hA5A5, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_GET_NEXT, 16'd11, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_FREE, 16'd11, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_GET_NEXT, 16'd11, 16'd0, 32'd0));
        // out-of-range clusters: below first data, one past the end, all ones
        pending_reqs.push_back(make_req(fct_pkg::OP_MARK_END, 16'd0, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_LINK, 16'd1, 16'hFFFF, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_GET_NEXT, 16'd12, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_FREE, 16'hFFFF, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd0, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd0, 16'd0, 32'd1));
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd0, 16'd0, 32'd1025));
        pending_reqs.push_back(make_req(fct_pkg::OP_GET_NEXT, 16'd4, 16'd0, 32'd0));
        // runs out of space, partial chain stays
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd0, 16'd0, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(fct_pkg::OP_FIND, 16'd0, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_GET_NEXT, 16'd11, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(OP_RSVD_6, 16'd2, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(OP_RSVD_7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(make_req(fct_pkg::OP_FREE, 16'd5, 16'd0, 32'd0));
        pending_reqs.push_back(make_req(fct_pkg::OP_FIND, 16'd0, 16'd0, 32'd0));
        wait_idle();

        // zero cluster size from either register
        write_reg(fct_pkg::CFG_SPC, 0);
        @(negedge i_clk);
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd0, 16'd0, 32'd1));
        wait_idle();
        write_reg(fct_pkg::CFG_SPC, 1);
        write_reg(fct_pkg::CFG_BPS, 0);
        @(negedge i_clk);
        pending_reqs.push_back(make_req(fct_pkg::OP_ALLOC, 16'd0, 16'd0, 32'd5));
        wait_idle();

        set_geometry(1, 30, 1, 512);
        gaps_on = 1'b1;
        hold_go = 1'b1;
        queue_random(40);
        wait_idle();

        set_geometry(1, 4094, 128, 4096);
        queue_random(15);
        wait_idle();

        set_geometry(1, 1, 255, 8191);
        gaps_on = 1'b0;
        queue_random(15);
        wait_idle();

        set_geometry(1, 200, 2, 1000);
        gaps_on = 1'b1;
        queue_random(35);
        wait_idle();

        write_reg(fct_pkg::CFG_MOUNTED, 0);
        @(negedge i_clk);
        gaps_on = 1'b0;
        queue_random(5);
        wait_idle();

        // total beyond the table depth saturates the valid range
        set_geometry(1, 4095, 1, 1);
        gaps_on = 1'b1;
        queue_random(15);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS fat_cluster_table_engine");
        end else begin
            $display("FAIL fat_cluster_table_engine");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/fct_pkg.sv
src/fct_req_if.sv
src/fct_rsp_if.sv
src/fct_alu.sv
src/fct_table.sv
src/fct_ctrl.sv
src/fat_cluster_table_engine.sv
bench/fat_cluster_table_engine_test.sv
